// ===== rtl/chacha20_stream_encryptor_unit_macros.svh =====
// assertion helpers shared by the rtl
`ifndef CHACHA20_STREAM_ENCRYPTOR_UNIT_MACROS_SVH
`define CHACHA20_STREAM_ENCRYPTOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define CC20_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cc20se_pkg.sv =====
package cc20se_pkg;

  localparam int WORD_W        = 32;
  localparam int BLOCK_WORDS   = 16;
  localparam int POS_W         = $clog2(BLOCK_WORDS);
  localparam int DOUBLE_ROUNDS = 10;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int CFG_IDX_W     = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [BLOCK_WORDS-1:0] blk_t;

  // rotate amounts of the four quarter-round steps, in step order
  typedef enum logic [1:0] {
    ROT_16,
    ROT_12,
    ROT_8,
    ROT_7
  } rot_sel_e;

endpackage

// ===== rtl/cc20se_qr_step.sv =====
module cc20se_qr_step
  import cc20se_pkg::*;
(
  input  word_t    p_i,
  input  word_t    q_i,
  input  word_t    r_i,
  input  rot_sel_e rot_i,
  output word_t    p_o,
  output word_t    r_o
);

  word_t sum;
  word_t mix;

  // p += q; r = rotl(r ^ p, n)
  assign sum = p_i + q_i;
  assign mix = r_i ^ sum;
  assign p_o = sum;

  always_comb begin
    case (rot_i)
      ROT_16:  r_o = {mix[15:0], mix[31:16]};
      ROT_12:  r_o = {mix[19:0], mix[31:20]};
      ROT_8:   r_o = {mix[23:0], mix[31:24]};
      ROT_7:   r_o = {mix[24:0], mix[31:25]};
      default: r_o = mix;
    endcase
  end

endmodule

// ===== rtl/chacha20_stream_encryptor_unit.sv =====
// Word-serial ChaCha20 encryptor.
// Input channel (in_valid_i/in_ready_o): one plaintext word with is_last_i and
// valid_bytes_i; a partial last word is left-aligned, its result right-aligned.
// Output channel (out_valid_o/out_ready_i): one ciphertext word per input word,
// out_last_o copies is_last_i. Configuration (cfg_valid_i/cfg_ready_o) writes
// one 64-bit register per word: constants, key, nonce and the initial counter;
// indexes past the last register are dropped. Write it only while idle.
// The first word of every 16-word block runs a keystream block through one
// shared quarter-round step unit: one add/xor/rotate per cycle. Other words
// skip it and go from idle straight to the emit state. One word is in flight;
// in_ready_o is high in the idle state only. A finished word waits in the
// output register, so the next word is accepted and worked on while the
// receiver stalls; it is emitted once that register frees up. Reset clears
// the configuration registers to zero, empties the output register and
// starts a new message; the counter loads at each message start and wraps
// at 32 bits.
`include "chacha20_stream_encryptor_unit_macros.svh"

module chacha20_stream_encryptor_unit
  import cc20se_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          plain_word_i,
  input  logic                 is_last_i,
  input  logic [2:0]           valid_bytes_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          cipher_word_o,
  output logic                 out_last_o
);

  localparam logic [2:0] REG_CONST01    = 3'd0;
  localparam logic [2:0] REG_CONST23    = 3'd1;
  localparam logic [2:0] REG_KEY01      = 3'd2;
  localparam logic [2:0] REG_KEY23      = 3'd3;
  localparam logic [2:0] REG_KEY45      = 3'd4;
  localparam logic [2:0] REG_KEY67      = 3'd5;
  localparam logic [2:0] REG_NONCE01    = 3'd6;
  localparam logic [2:0] REG_NONCE2_CTR = 3'd7;

  localparam logic [3:0] LAST_DROUND = 4'(DOUBLE_ROUNDS - 1);

  // per-row left rotation amounts, row 0 in the low bits
  localparam logic [3:0][1:0] SHIFT_COL    = {2'd1, 2'd1, 2'd1, 2'd1};
  localparam logic [3:0][1:0] SHIFT_DIAG   = {2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic [3:0][1:0] SHIFT_UNDIAG = {2'd1, 2'd2, 2'd3, 2'd0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DIAG,
    ST_UNDIAG,
    ST_FINAL,
    ST_EMIT
  } state_e;

  function automatic word_t bswap32(word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic blk_t row_rotl(blk_t s, logic [3:0][1:0] k);
    blk_t       o;
    logic [1:0] src;
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 4; i++) begin
        src = 2'(i) + k[r];
        o[{2'(r), 2'(i)}] = s[{2'(r), src}];
      end
    end
    return o;
  endfunction

  logic [NUM_REGS-1:0][REG_W-1:0] cfg_q;

  state_e         state_q;
  logic [1:0]     step_q;
  logic [1:0]     lane_q;
  logic           half_q;
  logic [3:0]     dround_q;
  logic [POS_W-1:0] pos_q;
  logic           started_q;
  word_t          ctr_q;
  logic           out_valid_q;
  word_t          cipher_q;
  logic           out_last_q;

  word_t      plain_q;
  logic       last_q;
  logic [2:0] vb_q;

  blk_t  w_q;
  blk_t  w_d;
  blk_t  init_blk;
  blk_t  stepped;
  word_t qr_p;
  word_t qr_q;
  word_t qr_r;
  word_t qr_p_new;
  word_t qr_r_new;
  word_t mixed;
  word_t cipher_d;
  logic  out_load;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cipher_word_o = cipher_q;
  assign out_last_o    = out_last_q;
  assign out_load      = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && !cfg_index_i[CFG_IDX_W-1]) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // initial state for the block about to be generated
  always_comb begin
    init_blk[0]  = cfg_q[REG_CONST01][31:0];
    init_blk[1]  = cfg_q[REG_CONST01][63:32];
    init_blk[2]  = cfg_q[REG_CONST23][31:0];
    init_blk[3]  = cfg_q[REG_CONST23][63:32];
    init_blk[4]  = bswap32(cfg_q[REG_KEY01][31:0]);
    init_blk[5]  = bswap32(cfg_q[REG_KEY01][63:32]);
    init_blk[6]  = bswap32(cfg_q[REG_KEY23][31:0]);
    init_blk[7]  = bswap32(cfg_q[REG_KEY23][63:32]);
    init_blk[8]  = bswap32(cfg_q[REG_KEY45][31:0]);
    init_blk[9]  = bswap32(cfg_q[REG_KEY45][63:32]);
    init_blk[10] = bswap32(cfg_q[REG_KEY67][31:0]);
    init_blk[11] = bswap32(cfg_q[REG_KEY67][63:32]);
    init_blk[12] = ctr_q;
    init_blk[13] = bswap32(cfg_q[REG_NONCE01][31:0]);
    init_blk[14] = bswap32(cfg_q[REG_NONCE01][63:32]);
    init_blk[15] = bswap32(cfg_q[REG_NONCE2_CTR][31:0]);
  end

  // quarter rounds always work on column 0; rows rotate past it
  always_comb begin
    qr_p = step_q[0] ? w_q[8]  : w_q[0];
    qr_q = step_q[0] ? w_q[12] : w_q[4];
    qr_r = step_q[0] ? w_q[4]  : w_q[12];
  end

  cc20se_qr_step u_qr_step (
    .p_i   (qr_p),
    .q_i   (qr_q),
    .r_i   (qr_r),
    .rot_i (rot_sel_e'(step_q)),
    .p_o   (qr_p_new),
    .r_o   (qr_r_new)
  );

  always_comb begin
    stepped = w_q;
    if (step_q[0]) begin
      stepped[8] = qr_p_new;
      stepped[4] = qr_r_new;
    end else begin
      stepped[0]  = qr_p_new;
      stepped[12] = qr_r_new;
    end
  end

  always_comb begin
    w_d = w_q;
    case (state_q)
      ST_LOAD:   w_d = init_blk;
      ST_ROUND:  w_d = (step_q == 2'd3) ? row_rotl(stepped, SHIFT_COL) : stepped;
      ST_DIAG:   w_d = row_rotl(w_q, SHIFT_DIAG);
      ST_UNDIAG: w_d = row_rotl(w_q, SHIFT_UNDIAG);
      ST_FINAL: begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          w_d[i] = bswap32(w_q[i] + init_blk[i]);
        end
      end
      default:   w_d = w_q;
    endcase
  end

  // the work registers end up holding the keystream block
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      plain_q <= plain_word_i;
      last_q  <= is_last_i;
      vb_q    <= valid_bytes_i;
    end
  end

  always_comb begin
    mixed    = plain_q ^ w_q[pos_q];
    cipher_d = mixed;
    if (last_q) begin
      case (vb_q)
        3'd1:    cipher_d = {24'd0, mixed[31:24]};
        3'd2:    cipher_d = {16'd0, mixed[31:16]};
        3'd3:    cipher_d = {8'd0, mixed[31:8]};
        default: cipher_d = mixed;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      lane_q      <= '0;
      half_q      <= 1'b0;
      dround_q    <= '0;
      pos_q       <= '0;
      started_q   <= 1'b0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
      cipher_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (!started_q) begin
              ctr_q     <= cfg_q[REG_NONCE2_CTR][63:32];
              started_q <= 1'b1;
            end
            state_q <= (pos_q == '0) ? ST_LOAD : ST_EMIT;
          end
        end
        ST_LOAD: begin
          step_q   <= '0;
          lane_q   <= '0;
          half_q   <= 1'b0;
          dround_q <= '0;
          state_q  <= ST_ROUND;
        end
        ST_ROUND: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            lane_q <= lane_q + 2'd1;
            if (lane_q == 2'd3) begin
              state_q <= half_q ? ST_UNDIAG : ST_DIAG;
            end
          end
        end
        ST_DIAG: begin
          half_q  <= 1'b1;
          state_q <= ST_ROUND;
        end
        ST_UNDIAG: begin
          half_q <= 1'b0;
          if (dround_q == LAST_DROUND) begin
            state_q <= ST_FINAL;
          end else begin
            dround_q <= dround_q + 4'd1;
            state_q  <= ST_ROUND;
          end
        end
        ST_FINAL: begin
          ctr_q   <= ctr_q + 32'd1;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            cipher_q    <= cipher_d;
            out_last_q  <= last_q;
            if (last_q) begin
              pos_q     <= '0;
              started_q <= 1'b0;
            end else begin
              pos_q <= pos_q + POS_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `CC20_ASSERT_NEXT(a_block_start, in_valid_i && in_ready_o && (pos_q == '0), state_q == ST_LOAD, "word at block start skipped keystream generation")

  `CC20_ASSERT_NEXT(a_ctr_step, state_q == ST_FINAL, ctr_q == $past(ctr_q) + 32'd1, "block counter did not advance by one")

  `CC20_ASSERT_NOW(a_out_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT, "output became valid outside emit")

  `CC20_ASSERT_NEXT(a_msg_end, out_load && last_q, (pos_q == '0) && !started_q, "message end did not rewind the block position")

  `CC20_ASSERT_NOW(a_round_bound, state_q == ST_ROUND, dround_q <= LAST_DROUND, "double round count overran")

endmodule
